[rtl/humidity_mold_alarm_fsm_macros.svh]
// ----------------------------------------------------------------------------
// Humidity mold alarm assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_MOLD_ALARM_FSM_MACROS_SVH
`define HUMIDITY_MOLD_ALARM_FSM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HMAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hmaf assertion failed");
// next-cycle implication
`define HMAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hmaf assertion failed");
`else
`define HMAF_ASSERT_IMP(lbl, ante, cons)
`define HMAF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/hmaf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmaf_pkg
// Shared widths and the sample record of the humidity mold alarm.
// ----------------------------------------------------------------------------
package hmaf_pkg;

  localparam int HUM_W   = 7;
  localparam int TEMP_W  = 11;
  localparam int CYCLE_W = 16;
  // integral step: |(hum - max) * cycle / 1000| < 2^14
  localparam int DELTA_W = 15;

  typedef struct packed {
    logic [HUM_W-1:0]         humidity;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_fault;
    logic                     remote_ack;
  } sample_t;

endpackage

[rtl/hmaf_delta.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmaf_delta
// Two-stage pipe computing (humidity - max) * cycle_ms / 1000, truncated
// toward zero, alongside the sample it belongs to.
// ----------------------------------------------------------------------------
module hmaf_delta import hmaf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  sample_t                   in_sample,
  input  logic [HUM_W-1:0]          max_humidity,
  input  logic [CYCLE_W-1:0]        cycle_ms,
  output logic                      out_valid,
  output sample_t                   out_sample,
  output logic signed [DELTA_W-1:0] delta
);

  localparam int PROD_W  = HUM_W + CYCLE_W + 2;   // signed product
  localparam int MAG_W   = PROD_W - 2;            // |product| < 2^23
  localparam int RECIP_W = 24;
  localparam int RECIP_SH = 33;
  // ceil(2^33 / 1000); exact floor for magnitudes below 2^23
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 1000 + 1);
  localparam int MUL_W = MAG_W + RECIP_W;
  localparam int Q_W   = DELTA_W - 1;

  logic                     valid_a;
  sample_t                  sample_a;
  logic signed [PROD_W-1:0] prod_a;
  logic                     valid_b;
  sample_t                  sample_b;
  logic [MUL_W-1:0]         prod_b;
  logic                     neg_b;

  logic signed [HUM_W:0]    diff;
  logic signed [PROD_W-1:0] prod_a_next;
  logic [MAG_W-1:0]         mag;
  logic [Q_W-1:0]           quot;

  always_comb begin
    diff        = $signed({1'b0, in_sample.humidity}) - $signed({1'b0, max_humidity});
    prod_a_next = PROD_W'(diff) * PROD_W'($signed({1'b0, cycle_ms}));
    mag         = prod_a[PROD_W-1] ? MAG_W'(-prod_a) : MAG_W'(prod_a);
    quot        = prod_b[RECIP_SH +: Q_W];
    delta       = neg_b ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_a <= in_sample;
      prod_a   <= prod_a_next;
      sample_b <= sample_a;
      prod_b   <= MUL_W'(mag) * MUL_W'(RECIP);
      neg_b    <= prod_a[PROD_W-1];
    end
  end

  assign out_valid  = valid_b;
  assign out_sample = sample_b;

endmodule

[rtl/humidity_mold_alarm_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_mold_alarm_fsm
// Mold alarm state machine driven by humidity / temperature sample ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Sample requests come in on s_* (tdata: humidity, temperature, remote_ack;
//   tuser: sensor_fault). One result request per sample leaves on m_* with
//   alarm_active, buzzer_on, red_led and mode_code.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data
//   while no sample is in flight; indexes above 6 are ignored.
//   From accept to m_tvalid, the integral-step product is registered with the
//   sample at accept, the reciprocal multiply takes one stage, and the state
//   update loads the result register. Throughput is one sample per cycle while
//   the output is not stalled; the state update is computed combinationally.
//   While m_tready is low with a result held, the whole pipe freezes and
//   s_tready drops; nothing is lost or repeated.
//   Synchronous reset puts the mode in boot, clears hold-off, integral,
//   buzzer and LED, and loads the default register values.
// ----------------------------------------------------------------------------
`include "humidity_mold_alarm_fsm_macros.svh"

module humidity_mold_alarm_fsm import hmaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // humidity[6:0], temperature[17:7], remote_ack[18]
  input  logic        s_tuser,   // sensor_fault[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // alarm_active[0], buzzer_on[1], red_led[2], mode_code[5:3]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] CFG_MAX_HUM   = 3'd0;
  localparam logic [2:0] CFG_NORM_HUM  = 3'd1;
  localparam logic [2:0] CFG_DIS_TEMP  = 3'd2;
  localparam logic [2:0] CFG_HYST      = 3'd3;
  localparam logic [2:0] CFG_HUM_SEC   = 3'd4;
  localparam logic [2:0] CFG_CYCLE     = 3'd5;
  localparam logic [2:0] CFG_REARM     = 3'd6;

  localparam int MS_PER_MIN = 60 * 1000;
  localparam int FULL_HUM   = 100;
  localparam int INT_W      = 40;
  localparam int HOLD_W     = 32;
  localparam int REARM_W    = 11;
  localparam int SEC_W      = 16;
  localparam int HYST_W     = 8;
  localparam int THR_W      = HUM_W + SEC_W + 2;
  localparam int REARM_MS_W = 27;
  localparam int T2_W       = TEMP_W + 3;

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_RUN      = 3'd1,
    MODE_PREALARM = 3'd2,
    MODE_ALARM    = 3'd3,
    MODE_DISABLED = 3'd4,
    MODE_ERROR    = 3'd5
  } mode_t;

  // configuration
  logic [HUM_W-1:0]         max_humidity;
  logic [HUM_W-1:0]         normal_humidity;
  logic signed [TEMP_W-1:0] disable_temp;
  logic [HYST_W-1:0]        temp_hysteresis;
  logic [SEC_W-1:0]         max_humid_seconds;
  logic [CYCLE_W-1:0]       cycle_ms;
  logic [REARM_W-1:0]       rearm_minutes;
  logic signed [THR_W-1:0]  threshold;
  logic [REARM_MS_W-1:0]    rearm_ms;

  // state
  mode_t                    mode;
  logic [HOLD_W-1:0]        holdoff_ms;
  logic signed [INT_W-1:0]  humid_integral;
  logic                     buzzer_level;
  logic                     led_level;

  // result register
  logic                     out_alarm;

  logic                     adv;
  sample_t                  in_sample;
  logic                     c_valid;
  sample_t                  c_sample;
  logic signed [DELTA_W-1:0] delta;

  mode_t                    mode_next;
  mode_t                    mode_eff;
  logic [HOLD_W-1:0]        holdoff_next;
  logic signed [INT_W-1:0]  integral_next;
  logic                     buzzer_next;
  logic                     led_next;
  logic signed [T2_W-1:0]   t2;
  logic signed [T2_W-1:0]   d2;
  logic signed [T2_W-1:0]   band_hi;
  logic signed [T2_W-1:0]   band_lo;
  logic signed [INT_W:0]    sum;
  logic signed [INT_W-1:0]  sum_sat;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  assign in_sample.humidity     = s_tdata[6:0];
  assign in_sample.temperature  = s_tdata[17:7];
  assign in_sample.remote_ack   = s_tdata[18];
  assign in_sample.sensor_fault = s_tuser;

  hmaf_delta u_delta (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .in_valid     (s_tvalid),
    .in_sample    (in_sample),
    .max_humidity (max_humidity),
    .cycle_ms     (cycle_ms),
    .out_valid    (c_valid),
    .out_sample   (c_sample),
    .delta        (delta)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_humidity      <= HUM_W'(85);
      normal_humidity   <= HUM_W'(75);
      disable_temp      <= TEMP_W'(280);
      temp_hysteresis   <= HYST_W'(10);
      max_humid_seconds <= SEC_W'(5400);
      cycle_ms          <= CYCLE_W'(400);
      rearm_minutes     <= REARM_W'(60);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_HUM:  max_humidity      <= cfg_data[HUM_W-1:0];
        CFG_NORM_HUM: normal_humidity   <= cfg_data[HUM_W-1:0];
        CFG_DIS_TEMP: disable_temp      <= cfg_data[TEMP_W-1:0];
        CFG_HYST:     temp_hysteresis   <= cfg_data[HYST_W-1:0];
        CFG_HUM_SEC:  max_humid_seconds <= cfg_data[SEC_W-1:0];
        CFG_CYCLE:    cycle_ms          <= cfg_data[CYCLE_W-1:0];
        CFG_REARM:    rearm_minutes     <= cfg_data[REARM_W-1:0];
        default: ;
      endcase
    end
  end

  // derived from configuration only; registered from the configuration registers
  always_ff @(posedge clk) begin
    threshold <= THR_W'($signed((HUM_W + 1)'(FULL_HUM)) - $signed({1'b0, max_humidity}))
                 * THR_W'($signed({1'b0, max_humid_seconds}));
    rearm_ms  <= REARM_MS_W'(rearm_minutes) * REARM_MS_W'(MS_PER_MIN);
  end

  always_comb begin
    mode_next     = mode;
    holdoff_next  = holdoff_ms;
    integral_next = humid_integral;
    buzzer_next   = buzzer_level;
    led_next      = led_level;

    t2      = T2_W'(c_sample.temperature) <<< 1;
    d2      = T2_W'(disable_temp) <<< 1;
    band_hi = d2 + $signed(T2_W'(temp_hysteresis));
    band_lo = d2 - $signed(T2_W'(temp_hysteresis));

    sum = (INT_W + 1)'(humid_integral) + (INT_W + 1)'(delta);
    if (sum[INT_W] != sum[INT_W-1])
      sum_sat = sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    else
      sum_sat = sum[INT_W-1:0];

    mode_eff = mode;
    if (c_sample.sensor_fault)
      mode_eff = MODE_ERROR;
    else if (t2 > band_hi)
      mode_eff = MODE_DISABLED;

    case (mode_eff)
      MODE_BOOT: begin
        mode_next   = MODE_RUN;
        buzzer_next = 1'b0;
        led_next    = 1'b0;
      end
      MODE_RUN: begin
        mode_next = MODE_RUN;
        if (holdoff_ms < HOLD_W'(cycle_ms)) begin
          if (c_sample.humidity > max_humidity)
            mode_next = MODE_PREALARM;
        end else begin
          holdoff_next = holdoff_ms - HOLD_W'(cycle_ms);
        end
        buzzer_next = 1'b0;
        led_next    = 1'b0;
      end
      MODE_PREALARM: begin
        mode_next     = MODE_PREALARM;
        integral_next = sum_sat;
        if (sum_sat > INT_W'(threshold)) begin
          mode_next = MODE_ALARM;
        end else if (c_sample.humidity < normal_humidity) begin
          mode_next     = MODE_RUN;
          integral_next = '0;
        end
        buzzer_next = 1'b0;
        led_next    = !led_level;
      end
      MODE_ALARM: begin
        mode_next   = MODE_ALARM;
        buzzer_next = 1'b1;
        led_next    = !led_level;
        if (c_sample.remote_ack) begin
          integral_next = '0;
          mode_next     = MODE_RUN;
          holdoff_next  = HOLD_W'(rearm_ms);
        end
      end
      MODE_DISABLED: begin
        mode_next = (t2 < band_lo) ? MODE_BOOT : MODE_DISABLED;
      end
      default: begin
        // error (and any stray code) falls straight back to boot
        mode_next = MODE_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BOOT;
      holdoff_ms     <= '0;
      humid_integral <= '0;
      buzzer_level   <= 1'b0;
      led_level      <= 1'b0;
      m_tvalid       <= 1'b0;
      out_alarm      <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_valid;
      if (c_valid) begin
        mode           <= mode_next;
        holdoff_ms     <= holdoff_next;
        humid_integral <= integral_next;
        buzzer_level   <= buzzer_next;
        led_level      <= led_next;
        out_alarm      <= (mode == MODE_ALARM);
      end
    end
  end

  assign m_tdata = {2'b00, mode, led_level, buzzer_level, out_alarm};

  `HMAF_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
  `HMAF_ASSERT_NXT(a_state_frozen, !(adv && c_valid),
                   $stable(mode) && $stable(holdoff_ms) && $stable(humid_integral))
  `HMAF_ASSERT_IMP(a_error_not_stored, 1'b1, mode != MODE_ERROR)
  `HMAF_ASSERT_NXT(a_alarm_buzzes, adv && c_valid && mode == MODE_ALARM && !c_sample.sensor_fault
                   && !(t2 > band_hi), buzzer_level && out_alarm)

endmodule
